// ----- src/cdps_pkg.sv -----
// Shared constants and types for the counter delta share block.
`default_nettype none

package cdps_pkg;

    localparam int NUM_STATES  = 4;
    localparam int COUNT_W     = 32;
    localparam int SHARE_W     = 10;
    localparam int TOTAL_W     = 34;
    localparam int SCALE       = 1000;

    // full-width sum of all deltas, numerator of one share division
    localparam int SUM_W       = COUNT_W + $clog2(NUM_STATES);
    localparam int NUM_W       = SUM_W + SHARE_W;
    localparam int PROD_W      = COUNT_W + SHARE_W;
    localparam int LANE_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int CNT_W       = $clog2(SHARE_W + 1);

    localparam int IN_W        = NUM_STATES * COUNT_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = NUM_STATES * SHARE_W + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [NUM_W-1:0]       t_num;
    typedef logic [PROD_W-1:0]      t_prod;
    typedef logic [SHARE_W-1:0]     t_share;
    typedef logic [TOTAL_W-1:0]     t_total;
    typedef logic [LANE_W-1:0]      t_lane;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [IN_TDATA_W-1:0]  t_in_tdata;
    typedef logic [OUT_TDATA_W-1:0] t_out_tdata;

endpackage

`default_nettype wire

// ----- src/cdps_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module cdps_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  cdps_pkg::t_num      i_num,   // must be below divisor * 2^SHARE_W
    input  cdps_pkg::t_sum      i_div,
    output logic                o_done,
    output cdps_pkg::t_share    o_quot
);
    import cdps_pkg::*;

    t_sum           r_rem, n_rem;
    t_sum           r_div, n_div;
    t_share         r_low, n_low;
    t_share         r_quot, n_quot;
    t_cnt           r_cnt, n_cnt;
    logic           r_done, n_done;
    logic [SUM_W:0] w_trial;
    logic           w_ge;

    assign w_trial = {r_rem, r_low[SHARE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_rem  = r_rem;
        n_div  = r_div;
        n_low  = r_low;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_num[NUM_W-1:SHARE_W];
            n_low  = i_num[SHARE_W-1:0];
            n_div  = i_div;
            n_cnt  = CNT_W'(SHARE_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? SUM_W'(w_trial - {1'b0, r_div}) : w_trial[SUM_W-1:0];
            n_low  = {r_low[SHARE_W-2:0], 1'b0};
            n_quot = {r_quot[SHARE_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- src/counter_delta_permille_shares.sv -----
// Top level: per-counter permille share of the activity since the last sample.
// A beat accepted in S_IDLE passes the delta phase, then per counter a multiply
// step and a divider run, and last the hand-over to the output register.
// Only one beat is in work at a time; the pace is set by the single bit-serial divider
// shared by the four counters, 10 quotient bits each, and slows while a result is stalled.
// Reset (synchronous, active low) zeroes the stored sample and empties the output.
`default_nettype none

module counter_delta_permille_shares (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    // count_user [31:0], count_nice [63:32], count_system [95:64], count_idle [127:96]
    input  cdps_pkg::t_in_tdata     i_s_tdata,
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    // share_user [9:0], share_nice [19:10], share_system [29:20], share_idle [39:30],
    // total_delta [73:40], zero pad [79:74]
    output cdps_pkg::t_out_tdata    o_m_tdata
);
    import cdps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DELTA = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    // Per-counter lanes; each phase works on lane 0 and rotates the rest down,
    // so after NUM_STATES steps everything is back in counter order.
    t_count     r_cur   [NUM_STATES];
    t_count     n_cur   [NUM_STATES];
    t_count     r_prev  [NUM_STATES];
    t_count     n_prev  [NUM_STATES];
    t_count     r_delta [NUM_STATES];
    t_count     n_delta [NUM_STATES];
    t_share     r_share [NUM_STATES];
    t_share     n_share [NUM_STATES];
    t_sum       r_total, n_total;
    t_lane      r_lane, n_lane;
    logic       r_m_tvalid, n_m_tvalid;
    t_out_tdata r_m_tdata, n_m_tdata;

    t_count     w_diff;
    t_sum       w_sum;
    t_prod      w_prod;
    t_num       w_num;
    logic       w_start;
    logic       w_done;
    t_share     w_quot;
    logic       w_last;

    // wrap-safe increase: modulo 2^32 subtraction
    assign w_diff = r_cur[0] - r_prev[0];
    assign w_sum  = r_total + SUM_W'(w_diff);
    assign w_last = (r_lane == LANE_W'(NUM_STATES - 1));

    // rounded share numerator: delta * 1000 + total / 2
    assign w_prod = PROD_W'(r_delta[0]) * PROD_W'(SCALE);
    assign w_num  = NUM_W'(w_prod) + NUM_W'(r_total >> 1);

    cdps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_div   (r_total),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_delta    = r_delta;
        n_share    = r_share;
        n_total    = r_total;
        n_lane     = r_lane;
        n_m_tvalid = r_m_tvalid & ~i_m_tready;
        n_m_tdata  = r_m_tdata;
        w_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    for (int k = 0; k < NUM_STATES; k++) begin
                        n_cur[k] = i_s_tdata[k*COUNT_W +: COUNT_W];
                    end
                    n_total = '0;
                    n_lane  = '0;
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                for (int k = 0; k < NUM_STATES - 1; k++) begin
                    n_cur[k]   = r_cur[k+1];
                    n_prev[k]  = r_prev[k+1];
                    n_delta[k] = r_delta[k+1];
                end
                n_cur[NUM_STATES-1]   = r_cur[0];
                n_prev[NUM_STATES-1]  = r_cur[0];
                n_delta[NUM_STATES-1] = w_diff;
                n_total = w_sum;
                n_lane  = r_lane + LANE_W'(1);
                if (w_last) begin
                    // no activity at all: divide by one, every share is zero
                    n_total = (w_sum == '0) ? SUM_W'(1) : w_sum;
                    n_lane  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done) begin
                    for (int k = 0; k < NUM_STATES - 1; k++) begin
                        n_share[k] = r_share[k+1];
                        n_delta[k] = r_delta[k+1];
                    end
                    n_share[NUM_STATES-1] = w_quot;
                    n_delta[NUM_STATES-1] = r_delta[0];
                    n_lane  = r_lane + LANE_W'(1);
                    n_state = S_MUL;
                    if (w_last) begin
                        n_lane  = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // hand over to the output register once it is free
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = '0;
                    for (int k = 0; k < NUM_STATES; k++) begin
                        n_m_tdata[k*SHARE_W +: SHARE_W] = r_share[k];
                    end
                    n_m_tdata[NUM_STATES*SHARE_W +: TOTAL_W] = TOTAL_W'(r_total);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lane     <= '0;
            r_total    <= '0;
            r_m_tvalid <= 1'b0;
            for (int k = 0; k < NUM_STATES; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_lane     <= n_lane;
            r_total    <= n_total;
            r_m_tvalid <= n_m_tvalid;
            r_prev     <= n_prev;
        end
        r_cur     <= n_cur;
        r_delta   <= n_delta;
        r_share   <= n_share;
        r_m_tdata <= n_m_tdata;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

`default_nettype wire

// ----- src/cdps_checker.sv -----
// Port-level checks for the counter delta share block, bound to the top level.
`default_nettype none

module cdps_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    input  wire                     o_s_tready,
    input  cdps_pkg::t_in_tdata     i_s_tdata,
    input  wire                     o_m_tvalid,
    input  wire                     i_m_tready,
    input  cdps_pkg::t_out_tdata    o_m_tdata
);
    import cdps_pkg::*;

    // one sample at a time: accepting a beat closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input still open after accepting a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output beat dropped or changed while stalled");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[NUM_STATES*SHARE_W +: TOTAL_W] != '0))
        else $error("total change of zero on output");

    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[9:0] <= 10'd1000) && (o_m_tdata[19:10] <= 10'd1000)
                     && (o_m_tdata[29:20] <= 10'd1000) && (o_m_tdata[39:30] <= 10'd1000)))
        else $error("share above one thousand");

endmodule

bind counter_delta_permille_shares cdps_checker u_cdps_checker (.*);

`default_nettype wire
